>>> design/mcr_pkg.sv
// shared constants and octant tables for the midpoint circle rasterizer
package mcr_pkg;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    localparam int OCT_BITS = 3;
    localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
    localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

    // per octant: swap x and y, negate column offset, negate row offset
    localparam logic [7:0] OCT_SWAP  = 8'b1010_1010;
    localparam logic [7:0] OCT_NEG_X = 8'b1100_1100;
    localparam logic [7:0] OCT_NEG_Y = 8'b1111_0000;

    localparam int DEC_INIT   = 3;
    localparam int DEC_STEP_E = 6;
    localparam int DEC_STEP_D = 10;

endpackage

>>> design/mcr_cmd_if.sv
// command channel carrying start and advance items
interface mcr_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;

    modport source (output valid, mode, center_x, center_y, radius, input ready);
    modport sink   (input valid, mode, center_x, center_y, radius, output ready);
endinterface

>>> design/mcr_pixel_if.sv
// pixel channel carrying one plotted point per item
interface mcr_pixel_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] point_x;
    logic signed [COORD_BITS+1:0] point_y;
    logic [2:0]                   octant;
    logic                         point_valid;
    logic                         last;
    logic                         circle_done;

    modport source (output valid, point_x, point_y, octant, point_valid, last, circle_done,
                    input ready);
    modport sink   (input valid, point_x, point_y, octant, point_valid, last, circle_done,
                    output ready);
endinterface

>>> design/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer top level. A start item (mode 0) loads center and radius and a
// advance item (mode 1) moves one step; each emits the eight symmetric points of the current
// (x, y) on the pixel channel, one item per cycle unless pixel.ready stalls it, octant 7
// flagged last and, on the final step, circle_done. An advance with no circle active emits
// one item with point_valid low. The decision update happens when the command is accepted;
// items leave through the single pixel output port, and the next command is taken in the
// cycle the previous one's last point moves into the output register.
module midpoint_circle_rasterizer
    import mcr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic       clk,
    input  logic       rst_n,
    mcr_cmd_if.sink    cmd,
    mcr_pixel_if.source pixel
);

    localparam int SW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 2;
    localparam int DW = COORD_BITS + 5;
    localparam logic signed [DW-1:0] DecInit  = DW'(DEC_INIT);
    localparam logic signed [DW-1:0] DecStepE = DW'(DEC_STEP_E);
    localparam logic signed [DW-1:0] DecStepD = DW'(DEC_STEP_D);

    // circle state
    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [SW-1:0]  sx_reg, sx_next;
    logic signed [SW-1:0]  sy_reg, sy_next;
    logic signed [DW-1:0]  dec_reg, dec_next;
    logic                  running_reg, running_next;

    // step being emitted
    logic                  job_busy_reg, job_busy_next;
    logic                  job_idle_reg, job_idle_next;
    logic                  job_done_reg, job_done_next;
    logic [COORD_BITS-1:0] job_cx_reg, job_cx_next;
    logic [COORD_BITS-1:0] job_cy_reg, job_cy_next;
    logic signed [SW-1:0]  job_px_reg, job_px_next;
    logic signed [SW-1:0]  job_py_reg, job_py_next;
    logic [OCT_BITS-1:0]   oct_reg, oct_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic signed [PW-1:0]  out_x_reg, out_x_next;
    logic signed [PW-1:0]  out_y_reg, out_y_next;
    logic [OCT_BITS-1:0]   out_oct_reg, out_oct_next;
    logic                  out_pv_reg, out_pv_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    logic                  is_start;
    logic                  idle_adv;
    logic                  accept;
    logic                  out_load;
    logic                  emit;
    logic                  emit_last;
    logic [COORD_BITS-1:0] cur_cx, cur_cy;
    logic signed [SW-1:0]  cur_x, cur_y;
    logic signed [DW-1:0]  cur_d;
    logic signed [DW-1:0]  x_ext, xy_ext;
    logic signed [SW-1:0]  new_x, new_y;
    logic signed [DW-1:0]  new_d;
    logic                  new_done;
    logic signed [SW-1:0]  off_a, off_b;
    logic signed [PW-1:0]  base_x, base_y, ext_a, ext_b;

    always_comb
    begin
        is_start = (cmd.mode == MODE_START);
        idle_adv = !is_start && !running_reg;
        out_load = !out_valid_reg || pixel.ready;
        emit      = job_busy_reg && out_load;
        emit_last = job_idle_reg || (oct_reg == OCT_LAST);
        cmd.ready = !job_busy_reg || (emit && emit_last);
        accept    = cmd.valid && cmd.ready;

        // step state, from the command on a start
        if (is_start)
        begin
            cur_cx = cmd.center_x;
            cur_cy = cmd.center_y;
            cur_x  = '0;
            cur_y  = $signed({1'b0, cmd.radius});
            cur_d  = DecInit - $signed({4'b0000, cmd.radius, 1'b0});
        end
        else
        begin
            cur_cx = cx_reg;
            cur_cy = cy_reg;
            cur_x  = sx_reg;
            cur_y  = sy_reg;
            cur_d  = dec_reg;
        end

        x_ext  = {{(DW-SW){cur_x[SW-1]}}, cur_x};
        xy_ext = x_ext - {{(DW-SW){cur_y[SW-1]}}, cur_y};
        if (cur_d < 0)
        begin
            new_d = cur_d + (x_ext <<< 2) + DecStepE;
            new_y = cur_y;
        end
        else
        begin
            new_d = cur_d + (xy_ext <<< 2) + DecStepD;
            new_y = cur_y - SW'(1);
        end
        new_x    = cur_x + SW'(1);
        new_done = new_y < new_x;

        cx_next      = cx_reg;
        cy_next      = cy_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        dec_next     = dec_reg;
        running_next = running_reg;
        job_busy_next = job_busy_reg;
        job_idle_next = job_idle_reg;
        job_done_next = job_done_reg;
        job_cx_next   = job_cx_reg;
        job_cy_next   = job_cy_reg;
        job_px_next   = job_px_reg;
        job_py_next   = job_py_reg;
        oct_next      = oct_reg;

        if (emit)
        begin
            oct_next = oct_reg + OCT_BITS'(1);
            if (emit_last)
            begin
                job_busy_next = 1'b0;
            end
        end

        if (accept)
        begin
            job_busy_next = 1'b1;
            job_idle_next = idle_adv;
            job_done_next = new_done;
            job_cx_next   = cur_cx;
            job_cy_next   = cur_cy;
            job_px_next   = cur_x;
            job_py_next   = cur_y;
            oct_next      = OCT_FIRST;
            if (!idle_adv)
            begin
                cx_next      = cur_cx;
                cy_next      = cur_cy;
                sx_next      = new_x;
                sy_next      = new_y;
                dec_next     = new_d;
                running_next = !new_done;
            end
        end

        // symmetric point for the current octant
        off_a  = OCT_SWAP[oct_reg] ? job_py_reg : job_px_reg;
        off_b  = OCT_SWAP[oct_reg] ? job_px_reg : job_py_reg;
        ext_a  = {off_a[SW-1], off_a};
        ext_b  = {off_b[SW-1], off_b};
        base_x = $signed({2'b00, job_cx_reg});
        base_y = $signed({2'b00, job_cy_reg});

        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_oct_next   = out_oct_reg;
        out_pv_next    = out_pv_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (job_idle_reg)
            begin
                out_x_next    = '0;
                out_y_next    = '0;
                out_oct_next  = OCT_FIRST;
                out_pv_next   = 1'b0;
                out_last_next = 1'b1;
                out_done_next = 1'b1;
            end
            else
            begin
                out_x_next    = OCT_NEG_X[oct_reg] ? base_x - ext_a : base_x + ext_a;
                out_y_next    = OCT_NEG_Y[oct_reg] ? base_y - ext_b : base_y + ext_b;
                out_oct_next  = oct_reg;
                out_pv_next   = 1'b1;
                out_last_next = emit_last;
                out_done_next = emit_last && job_done_reg;
            end
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= '0;
            cy_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            dec_reg       <= '0;
            running_reg   <= 1'b0;
            job_busy_reg  <= 1'b0;
            oct_reg       <= OCT_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            dec_reg       <= dec_next;
            running_reg   <= running_next;
            job_busy_reg  <= job_busy_next;
            oct_reg       <= oct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_idle_reg <= job_idle_next;
        job_done_reg <= job_done_next;
        job_cx_reg   <= job_cx_next;
        job_cy_reg   <= job_cy_next;
        job_px_reg   <= job_px_next;
        job_py_reg   <= job_py_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_oct_reg  <= out_oct_next;
        out_pv_reg   <= out_pv_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.point_x     = out_x_reg;
    assign pixel.point_y     = out_y_reg;
    assign pixel.octant      = out_oct_reg;
    assign pixel.point_valid = out_pv_reg;
    assign pixel.last        = out_last_reg;
    assign pixel.circle_done = out_done_reg;

endmodule

>>> design/mcr_checker.sv
// port-level assertions for the midpoint circle rasterizer and their bind
module mcr_checker
    import mcr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_ready,
    input logic [2:0] octant,
    input logic       point_valid,
    input logic       last,
    input logic       circle_done
);

    // stalled item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(octant) && $stable(last))
    else $error("pixel item dropped or changed under stall");

    // a point item closes its command exactly at octant 7
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && point_valid |-> (last == (octant == OCT_LAST)))
    else $error("last flag does not match octant");

    // an empty item is a lone finished result
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !point_valid |-> last && circle_done && octant == OCT_FIRST)
    else $error("empty item malformed");

    // done only on the final item
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && circle_done |-> last)
    else $error("circle_done without last");

    // octants step in order within a command
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready && point_valid && !last ##1 pixel_valid
            |-> point_valid && octant == $past(octant) + 3'd1)
    else $error("octant sequence broken");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .octant      (pixel.octant),
    .point_valid (pixel.point_valid),
    .last        (pixel.last),
    .circle_done (pixel.circle_done)
);

>>> test/midpoint_circle_rasterizer_tb.sv
// testbench for the midpoint circle rasterizer: directed and random circles checked per point
module midpoint_circle_rasterizer_tb;
    import mcr_pkg::*;

    localparam int CB          = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CB+1:0] col;
        logic signed [CB+1:0] row;
        logic [2:0]           oct;
        logic                 plotted;
        logic                 last;
        logic                 done;
    } pixel_t;

    logic clk;
    logic rst_n;

    mcr_cmd_if   #(.COORD_BITS(CB)) cmd_ch ();
    mcr_pixel_if #(.COORD_BITS(CB)) pix_ch ();

    midpoint_circle_rasterizer #(.COORD_BITS(CB)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .pixel (pix_ch)
    );

    pixel_t          pending_pixels[$];
    logic [CB-1:0]   circ_cx     = '0;
    logic [CB-1:0]   circ_cy     = '0;
    int              circ_x      = 0;
    int              circ_y      = 0;
    int              circ_dec    = 0;
    bit              circ_active = 1'b0;
    int              err_cnt     = 0;
    int              cycle_cnt   = 0;
    bit              hold_req    = 1'b0;
    bit              quiet       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("midpoint_circle_rasterizer_tb: errors");
            $finish;
        end
    end

    // one step: eight symmetric points then the decision update, or one empty item if idle
    function automatic void plot_step(input logic m, input logic [CB-1:0] cx,
                                      input logic [CB-1:0] cy, input logic [CB-1:0] r);
        int     cur_x;
        int     cur_y;
        int     a;
        int     b;
        int     ox;
        int     oy;
        logic   fin;
        pixel_t p;
        if (m == MODE_START)
        begin
            circ_cx     = cx;
            circ_cy     = cy;
            circ_x      = 0;
            circ_y      = int'(r);
            circ_dec    = DEC_INIT - 2 * int'(r);
            circ_active = 1'b1;
        end
        else if (!circ_active)
        begin
            p.col     = '0;
            p.row     = '0;
            p.oct     = OCT_FIRST;
            p.plotted = 1'b0;
            p.last    = 1'b1;
            p.done    = 1'b1;
            pending_pixels.push_back(p);
            return;
        end
        cur_x = circ_x;
        cur_y = circ_y;
        if (circ_dec < 0)
            circ_dec = circ_dec + 4 * circ_x + DEC_STEP_E;
        else
        begin
            circ_dec = circ_dec + 4 * (circ_x - circ_y) + DEC_STEP_D;
            circ_y   = circ_y - 1;
        end
        circ_x = circ_x + 1;
        fin    = circ_y < circ_x;
        if (fin)
            circ_active = 1'b0;
        for (int k = 0; k < 8; k++)
        begin
            a         = OCT_SWAP[k] ? cur_y : cur_x;
            b         = OCT_SWAP[k] ? cur_x : cur_y;
            ox        = int'(circ_cx) + (OCT_NEG_X[k] ? -a : a);
            oy        = int'(circ_cy) + (OCT_NEG_Y[k] ? -b : b);
            p.col     = ox[CB+1:0];
            p.row     = oy[CB+1:0];
            p.oct     = 3'(k);
            p.plotted = 1'b1;
            p.last    = (3'(k) == OCT_LAST);
            p.done    = (3'(k) == OCT_LAST) && fin;
            pending_pixels.push_back(p);
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_cmd(input logic m, input logic [CB-1:0] cx,
                            input logic [CB-1:0] cy, input logic [CB-1:0] r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid    <= 1'b1;
        cmd_ch.mode     <= m;
        cmd_ch.center_x <= cx;
        cmd_ch.center_y <= cy;
        cmd_ch.radius   <= r;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        plot_step(m, cx, cy, r);
    endtask

    task automatic send_advance();
        send_cmd(MODE_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom));
    endtask

    task automatic wait_pixels_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(input string what, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t pixel %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        pixel_t want;
        if (pix_ch.valid && pix_ch.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected pixel item: expected none, actual x=%0d y=%0d oct=%0d",
                         $time, pix_ch.point_x, pix_ch.point_y, pix_ch.octant);
                err_cnt++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("point_x", want.col, pix_ch.point_x);
                check_field("point_y", want.row, pix_ch.point_y);
                check_field("octant", {29'd0, want.oct}, {29'd0, pix_ch.octant});
                check_field("point_valid", {31'd0, want.plotted}, {31'd0, pix_ch.point_valid});
                check_field("last", {31'd0, want.last}, {31'd0, pix_ch.last});
                check_field("circle_done", {31'd0, want.done}, {31'd0, pix_ch.circle_done});
            end
        end
    end

    // output side: random stalls, plus one long hold when requested
    initial
    begin
        int stall_left;
        int roll;
        stall_left   = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pix_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_left > 0)
            begin
                pix_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (quiet || roll < 70)
                    pix_ch.ready <= 1'b1;
                else
                begin
                    stall_left   = (roll < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                    pix_ch.ready <= 1'b0;
                end
            end
        end
    end

    task automatic test_idle_advance();
        send_advance();
        send_cmd(MODE_ADVANCE, '1, '1, '1);
    endtask

    task automatic test_zero_radius();
        send_cmd(MODE_START, '0, '0, '0);
        send_cmd(MODE_START, '1, '1, '0);
        send_advance();
    endtask

    // largest radius at three corners, abandoned after one or two steps
    task automatic test_far_offsets();
        send_cmd(MODE_START, '0, '0, '1);
        send_advance();
        send_advance();
        send_cmd(MODE_START, '1, '1, '1);
        send_advance();
        send_advance();
        send_cmd(MODE_START, '1, '0, '1);
        send_advance();
    endtask

    task automatic test_small_circles();
        int radii[3] = '{1, 2, 5};
        foreach (radii[i])
        begin
            send_cmd(MODE_START, CB'($urandom), CB'($urandom), CB'(radii[i]));
            while (circ_active)
                send_advance();
        end
        send_advance();
    endtask

    task automatic test_output_backpressure();
        quiet    = 1'b1;
        hold_req = 1'b1;
        send_cmd(MODE_START, CB'($urandom), CB'($urandom), CB'(20));
        repeat (9) send_advance();
        quiet = 1'b0;
        wait_pixels_drained();
    endtask

    task automatic test_random_circles(input int n_items);
        int          sent;
        int          kind;
        int          steps;
        logic [CB-1:0] r;
        sent = 0;
        while (sent < n_items)
        begin
            quiet = ($urandom_range(0, 5) == 0);
            kind  = $urandom_range(0, 9);
            if (kind < 6)
            begin
                r = ($urandom_range(0, 7) == 0) ? CB'($urandom_range(13, 40))
                                                : CB'($urandom_range(0, 12));
                send_cmd(MODE_START, CB'($urandom), CB'($urandom), r);
                sent++;
                while (circ_active)
                begin
                    send_advance();
                    sent++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    send_advance();
                    sent++;
                end
            end
            else if (kind < 8)
            begin
                send_cmd(MODE_START, CB'($urandom), CB'($urandom), CB'($urandom));
                sent++;
                steps = $urandom_range(0, 3);
                for (int i = 0; i < steps && circ_active; i++)
                begin
                    send_advance();
                    sent++;
                end
            end
            else
            begin
                steps = $urandom_range(1, 4);
                repeat (steps)
                begin
                    send_cmd(1'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
                    sent++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_pixels_drained();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.mode     = MODE_START;
        cmd_ch.center_x = '0;
        cmd_ch.center_y = '0;
        cmd_ch.radius   = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_advance();
        test_zero_radius();
        test_far_offsets();
        test_small_circles();
        test_output_backpressure();
        test_random_circles(175);
        wait_pixels_drained();
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("midpoint_circle_rasterizer_tb: clean");
        else
            $display("midpoint_circle_rasterizer_tb: errors");
        $finish;
    end

endmodule
